// ===== hw/rtl/rtd_pkg.sv =====
`default_nettype none

package rtd_pkg;

	localparam int DEF_MAX_RADIX  = 16;
	localparam int DEF_VALUE_BITS = 32;

	localparam int SYMBOL_W   = 8;
	localparam int SYM_COUNT  = 16;
	localparam int SYM_IDX_W  = 4;
	localparam int LENGTH_W   = 5;
	localparam int WORD_W     = 64;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOWER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_UPPER   = 2'd2;

	localparam logic [SYMBOL_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [SYMBOL_W-1:0] CHAR_DEL   = 8'h7F;

	// symbols 0..7 in the lower word, 8..15 in the upper, lowest byte first
	function automatic logic [SYMBOL_W-1:0] symbol_at(
		input logic [WORD_W-1:0]    lower,
		input logic [WORD_W-1:0]    upper,
		input logic [SYM_IDX_W-1:0] idx
	);
		logic [WORD_W-1:0] word;
		begin
			word = idx[SYM_IDX_W-1] ? upper : lower;
			symbol_at = word[idx[SYM_IDX_W-2:0]*SYMBOL_W +: SYMBOL_W];
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtd_alpha_check.sv =====
`default_nettype none

module rtd_alpha_check #(
	parameter int MAX_RADIX = rtd_pkg::DEF_MAX_RADIX
) (
	input  wire logic [rtd_pkg::LENGTH_W-1:0] length,
	input  wire logic [rtd_pkg::WORD_W-1:0]   lower,
	input  wire logic [rtd_pkg::WORD_W-1:0]   upper,
	output logic                              ok
);

	logic [rtd_pkg::SYMBOL_W-1:0] sym [rtd_pkg::SYM_COUNT];
	logic                         bad;

	always_comb begin
		for (int i = 0; i < rtd_pkg::SYM_COUNT; i++) begin
			sym[i] = rtd_pkg::symbol_at(lower, upper, rtd_pkg::SYM_IDX_W'(i));
		end
	end

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < rtd_pkg::SYM_COUNT; i++) begin
			if (rtd_pkg::LENGTH_W'(i) < length) begin
				if (sym[i] <= rtd_pkg::CHAR_SPACE || sym[i] >= rtd_pkg::CHAR_DEL ||
				    sym[i] == rtd_pkg::CHAR_PLUS || sym[i] == rtd_pkg::CHAR_MINUS)
					bad = 1'b1;
				// j in use implies i in use
				for (int j = i + 1; j < rtd_pkg::SYM_COUNT; j++) begin
					if (rtd_pkg::LENGTH_W'(j) < length && sym[j] == sym[i])
						bad = 1'b1;
				end
			end
		end
		ok = !bad && length >= rtd_pkg::LENGTH_W'(2)
			&& length <= rtd_pkg::LENGTH_W'(MAX_RADIX);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rtd_divider.sv =====
`default_nettype none

module rtd_divider #(
	parameter int VALUE_BITS = rtd_pkg::DEF_VALUE_BITS,
	parameter int DIGIT_W    = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [DIGIT_W:0]      divisor,
	output logic                       done,
	output logic [VALUE_BITS-1:0]      quotient,
	output logic [DIGIT_W-1:0]         remainder
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [DIGIT_W:0]      div_q;
	logic [DIGIT_W:0]      rem_sh;
	logic                  ge;
	logic [DIGIT_W:0]      rem_diff;

	// restoring step: one quotient bit per cycle
	assign rem_sh   = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge       = rem_sh >= div_q;
	assign rem_diff = rem_sh - div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
		end else if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_radix_digits_core.sv =====
`default_nettype none

// Writes one signed VALUE_BITS-bit integer as text in the radix of the configured
// alphabet (alphabet_length symbols taken from symbols_lower/symbols_upper). A bad
// alphabet (fewer than two or more than MAX_RADIX symbols, a repeat, a space, a
// control byte, 127 or above, '+' or '-') gives no characters at all. Otherwise a
// '-' leads for a negative value, then the digits follow most significant first,
// with last set on the final character. One number at a time: value_stall stays
// high from acceptance until the last character has been loaded into the output
// register. The time is set by the shared restoring divider, which works out one
// digit at a time, each one finished before the next is started, plus any output
// stall. Write the registers only while idle.
module integer_to_radix_digits_core #(
	parameter int MAX_RADIX  = rtd_pkg::DEF_MAX_RADIX,
	parameter int VALUE_BITS = rtd_pkg::DEF_VALUE_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rtd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rtd_pkg::WORD_W-1:0]          cfg_data,
	input  wire logic                                value_valid,
	output logic                                     value_stall,
	input  wire logic signed [VALUE_BITS-1:0]        value,
	output logic                                     text_valid,
	input  wire logic                                text_stall,
	output logic [rtd_pkg::SYMBOL_W-1:0]             character,
	output logic                                     last
);

	localparam int DIGIT_W = $clog2(MAX_RADIX);
	localparam int AW      = $clog2(VALUE_BITS);
	localparam int CW      = $clog2(VALUE_BITS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]                      state_q;
	logic [rtd_pkg::LENGTH_W-1:0]    length_q;
	logic [rtd_pkg::WORD_W-1:0]      lower_q;
	logic [rtd_pkg::WORD_W-1:0]      upper_q;
	logic [VALUE_BITS-1:0]           mag_q;
	logic                            neg_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   count_m1;
	logic                            text_valid_q;
	logic [rtd_pkg::SYMBOL_W-1:0]    char_q;
	logic                            last_q;
	logic [DIGIT_W-1:0]              digit_mem [VALUE_BITS];
	logic [DIGIT_W-1:0]              rd_q;
	logic                            alpha_ok;
	logic                            out_free;
	logic                            load_out;
	logic                            div_start;
	logic                            div_done;
	logic [VALUE_BITS-1:0]           div_dividend;
	logic [VALUE_BITS-1:0]           div_quo;
	logic [DIGIT_W-1:0]              div_rem;

	rtd_alpha_check #(
		.MAX_RADIX(MAX_RADIX)
	) u_check (
		.length(length_q),
		.lower (lower_q),
		.upper (upper_q),
		.ok    (alpha_ok)
	);

	assign div_start = (state_q == ST_CHECK && alpha_ok)
		|| (state_q == ST_DIV && div_done && div_quo != '0);
	assign div_dividend = (state_q == ST_CHECK) ? mag_q : div_quo;

	rtd_divider #(
		.VALUE_BITS(VALUE_BITS),
		.DIGIT_W   (DIGIT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (length_q[DIGIT_W:0]),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign out_free    = !text_valid_q || !text_stall;
	assign load_out    = out_free && ((state_q == ST_SIGN && neg_q) || state_q == ST_EMIT);
	assign count_m1    = count_q - 1'b1;
	assign cfg_ready   = 1'b1;
	assign value_stall = (state_q != ST_IDLE);

	// digits land least significant first and are read back from the top
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done)
			digit_mem[count_q[AW-1:0]] <= div_rem;
		rd_q <= digit_mem[count_m1[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			length_q     <= '0;
			lower_q      <= '0;
			upper_q      <= '0;
			count_q      <= '0;
			text_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					rtd_pkg::REG_ALPHABET_LENGTH: length_q <= cfg_data[rtd_pkg::LENGTH_W-1:0];
					rtd_pkg::REG_SYMBOLS_LOWER:   lower_q  <= cfg_data;
					rtd_pkg::REG_SYMBOLS_UPPER:   upper_q  <= cfg_data;
					default: ;
				endcase
			end
			if (load_out)
				text_valid_q <= 1'b1;
			else if (text_valid_q && !text_stall)
				text_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (value_valid)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					count_q <= '0;
					state_q <= alpha_ok ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done) begin
						count_q <= count_q + 1'b1;
						if (div_quo == '0)
							state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					if (!neg_q || out_free)
						state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						count_q <= count_m1;
						state_q <= (count_q == CW'(1)) ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && value_valid) begin
			neg_q <= value[VALUE_BITS-1];
			mag_q <= value[VALUE_BITS-1] ? (~$unsigned(value) + 1'b1) : $unsigned(value);
		end
		if (state_q == ST_SIGN && neg_q && out_free) begin
			char_q <= rtd_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			char_q <= rtd_pkg::symbol_at(lower_q, upper_q, rtd_pkg::SYM_IDX_W'(rd_q));
			last_q <= (count_q == CW'(1));
		end
	end

	assign text_valid = text_valid_q;
	assign character  = char_q;
	assign last       = last_q;

`ifndef NO_ASSERTIONS
	a_emit_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (count_q != '0))
		else $error("emit with no digits left");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the digit loop");

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && !value_stall) |=> (state_q == ST_CHECK))
		else $error("accepted transaction did not start the alphabet check");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_done) |-> (count_q < CW'(VALUE_BITS)))
		else $error("digit store overflow");
`endif

endmodule

`default_nettype wire
